// ----- hw/rtl/ecpa_pkg.sv -----
package ecpa_pkg;

  localparam int FieldBits  = 31;
  localparam int ScalarBits = 64;
  localparam int CmdBits    = 2;
  localparam int IdxBits    = 1;

  localparam logic [FieldBits-1:0] ModulusReset = {FieldBits{1'b1}};

  typedef logic [FieldBits-1:0] fe_t;

  // Affine point as held in the working memory.
  typedef struct packed {
    fe_t x;
    fe_t y;
  } pt_t;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD = 2'd0,
    CMD_DBL = 2'd1,
    CMD_MUL = 2'd2,
    CMD_SUB = 2'd3
  } cmd_t;

  typedef enum logic [IdxBits-1:0] {
    REG_MODULUS = 1'b0,
    REG_CURVE_A = 1'b1
  } reg_idx_t;

  // Field operation requested of the modular multiply unit.
  typedef struct packed {
    logic start;
    fe_t  a;
    fe_t  b;
  } mm_req_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_RED,
    S_REDW,
    S_SEL,
    S_ADDCHK,
    S_DBLCHK,
    S_SQX,
    S_SQXW,
    S_INV_INIT,
    S_INV_MUL,
    S_INV_MULW,
    S_INV_SQ,
    S_INV_SQW,
    S_SLOPE,
    S_SLOPEW,
    S_MSQ,
    S_MSQW,
    S_YMUL,
    S_YMULW,
    S_FIN,
    S_MUL_CLR,
    S_MUL_INIT,
    S_MUL_STEP,
    S_MUL_RDA,
    S_MUL_RDB,
    S_MUL_RDT,
    S_MUL_LAST,
    S_MUL_ADDDONE,
    S_MUL_DBLDONE,
    S_OUT
  } state_t;

endpackage

// ----- hw/rtl/ec_point_arith_prime_field_unit.sv -----
// Affine elliptic-curve point unit over GF(modulus): add, double, subtract and
// 64-bit right-to-left double-and-add scalar multiply, one word at a time.
// (0,0) is the point at infinity. Every field product runs through one
// bit-serial modular multiplier. Each slope needs an inverse by Fermat's
// exponentiation over all 31 exponent bits: 31 squarings plus one product per
// set bit of modulus-2. A scalar multiply runs 64 rounds of an optional add
// and a double. Before any of this the five inputs x1, y1, x2, y2 and curve_a
// are reduced by a restoring remainder. The accumulator, the doubling point
// and the reduced curve_a sit in a small synchronous memory with a registered
// read. A modulus below 3 gives infinity without any reduction or arithmetic.
// Input is accepted only when the previous result has been taken.
module ec_point_arith_prime_field_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ecpa_pkg::IdxBits-1:0]       cfg_index,
  input  logic [ecpa_pkg::FieldBits-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ecpa_pkg::CmdBits-1:0]       cmd,
  input  logic [ecpa_pkg::FieldBits-1:0]     x1,
  input  logic [ecpa_pkg::FieldBits-1:0]     y1,
  input  logic [ecpa_pkg::FieldBits-1:0]     x2,
  input  logic [ecpa_pkg::FieldBits-1:0]     y2,
  input  logic [ecpa_pkg::ScalarBits-1:0]    scalar,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ecpa_pkg::FieldBits-1:0]     x_out,
  output logic [ecpa_pkg::FieldBits-1:0]     y_out,
  output logic                               at_infinity
);
  import ecpa_pkg::*;

  localparam int FeW = FieldBits;
  localparam int ScCntBits = $clog2(ScalarBits + 1);
  localparam int ExpCntBits = $clog2(FeW + 1);

  // Working memory addresses.
  typedef enum logic [1:0] {
    R_ACC, R_T, R_A
  } raddr_t;

  fe_t modulus;
  fe_t curve_a;

  pt_t    rf [0:2];
  pt_t    rf_rdata;
  raddr_t rf_raddr;
  raddr_t rf_waddr;
  logic   rf_we;
  pt_t    rf_wdata;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    rf_rdata <= rf[rf_raddr];
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModulusReset;
      curve_a <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODULUS: modulus <= cfg_data;
        REG_CURVE_A: curve_a <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Shared multiplier.
  mm_req_t mreq;
  logic    mdone;
  fe_t     mprod;
  ecpa_modmul u_mm (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .m    (modulus),
    .done (mdone),
    .prod (mprod)
  );

  // Working registers.
  cmd_t                  cmd_q;
  logic [ScalarBits-1:0] scal_q;
  logic [ScCntBits-1:0]  bit_cnt;
  logic [2:0]            red_idx;
  fe_t  px, py, qx, qy;      // current operation operands
  logic op_dbl;              // current operation is doubling
  logic op_from_mul;         // operation belongs to scalar loop
  logic op_is_add;           // in scalar loop: add step (else double)
  fe_t  num, den, slope, rx;
  fe_t  inv_r, inv_b;
  fe_t  exp_q;
  logic [ExpCntBits-1:0] exp_cnt;
  fe_t  res_x, res_y;
  logic res_valid;

  // Modular helpers, each one add or subtract with a single correction.
  function automatic fe_t fadd(fe_t a, fe_t b, fe_t m);
    logic [FeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    fadd = (s >= {1'b0, m}) ? FeW'(s - {1'b0, m}) : FeW'(s);
  endfunction
  function automatic fe_t fsub(fe_t a, fe_t b, fe_t m);
    fsub = (a >= b) ? a - b : FeW'({1'b0, a} + {1'b0, m} - {1'b0, b});
  endfunction

  logic small_mod;
  assign small_mod = (modulus < FeW'(3));

  assign in_stall  = (state != S_IDLE) || res_valid;
  assign out_valid = res_valid;

  logic accept;
  assign accept = in_valid && !in_stall;

  // Reduction of a raw 31-bit value mod m by a restoring remainder,
  // one bit per cycle.
  fe_t  red_val;
  fe_t  red_rem;
  logic [ExpCntBits-1:0] red_cnt;

  logic [FeW:0] rr_shift;
  always_comb rr_shift = {red_rem, red_val[FeW-1]};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier requests and memory accesses.
  always_comb begin
    state_next = state;
    mreq       = '0;
    rf_we      = 1'b0;
    rf_waddr   = R_A;
    rf_wdata   = '0;
    rf_raddr   = R_A;
    unique case (state)
      S_IDLE: if (accept) state_next = small_mod ? S_OUT : S_RED;
      S_RED:  state_next = S_REDW;
      S_REDW: if (red_cnt == '0) state_next = (red_idx == 3'd4) ? S_SEL : S_RED;
      S_SEL: begin
        rf_we    = 1'b1;
        rf_waddr = R_A;
        rf_wdata = '{x: num, y: '0};
        unique case (cmd_q) inside
          CMD_ADD, CMD_SUB: state_next = S_ADDCHK;
          CMD_DBL:          state_next = S_DBLCHK;
          default:          state_next = S_MUL_CLR;
        endcase
      end
      S_ADDCHK: begin
        if ((px == '0 && py == '0) || (qx == '0 && qy == '0)) begin
          state_next = S_FIN;
        end else if (px == qx) begin
          state_next = (py == qy) ? S_DBLCHK : S_FIN;
        end else begin
          state_next = S_INV_INIT;
        end
      end
      S_DBLCHK: state_next = (py == '0) ? S_FIN : S_SQX;
      S_SQX: begin
        mreq       = '{start: 1'b1, a: px, b: px};
        state_next = S_SQXW;
      end
      S_SQXW: if (mdone) state_next = S_INV_INIT;
      S_INV_INIT: state_next = S_INV_MUL;
      S_INV_MUL: begin
        mreq       = '{start: exp_q[0], a: inv_r, b: inv_b};
        state_next = exp_q[0] ? S_INV_MULW : S_INV_SQ;
      end
      S_INV_MULW: if (mdone) state_next = S_INV_SQ;
      S_INV_SQ: begin
        mreq       = '{start: 1'b1, a: inv_b, b: inv_b};
        state_next = S_INV_SQW;
      end
      S_INV_SQW: begin
        if (mdone) state_next = (exp_cnt == ExpCntBits'(1)) ? S_SLOPE : S_INV_MUL;
      end
      S_SLOPE: begin
        mreq       = '{start: 1'b1, a: num, b: inv_r};
        state_next = S_SLOPEW;
      end
      S_SLOPEW: if (mdone) state_next = S_MSQ;
      S_MSQ: begin
        mreq       = '{start: 1'b1, a: slope, b: slope};
        state_next = S_MSQW;
      end
      S_MSQW: if (mdone) state_next = S_YMUL;
      S_YMUL: begin
        mreq       = '{start: 1'b1, a: slope, b: fsub(px, rx, modulus)};
        state_next = S_YMULW;
      end
      S_YMULW: if (mdone) state_next = S_FIN;
      // Finish: deliver or return to the scalar loop.
      S_FIN: begin
        if (!op_from_mul) begin
          state_next = S_OUT;
        end else begin
          rf_we      = 1'b1;
          rf_waddr   = op_is_add ? R_ACC : R_T;
          rf_wdata   = '{x: res_x, y: res_y};
          state_next = op_is_add ? S_MUL_ADDDONE : S_MUL_DBLDONE;
        end
      end
      // Scalar loop: for each bit, optional acc += t, then t = 2t.
      S_MUL_CLR: begin
        rf_we      = 1'b1;
        rf_waddr   = R_ACC;
        rf_wdata   = '0;
        state_next = S_MUL_INIT;
      end
      S_MUL_INIT: begin
        rf_we      = 1'b1;
        rf_waddr   = R_T;
        rf_wdata   = '{x: px, y: py};
        state_next = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        if (bit_cnt == ScCntBits'(ScalarBits)) begin
          rf_raddr   = R_ACC;
          state_next = S_MUL_LAST;
        end else if (scal_q[0]) begin
          rf_raddr   = R_ACC;
          state_next = S_MUL_RDA;
        end else begin
          rf_raddr   = R_T;
          state_next = S_MUL_RDT;
        end
      end
      S_MUL_RDA: begin
        rf_raddr   = R_T;
        state_next = S_MUL_RDB;
      end
      S_MUL_RDB:  state_next = S_ADDCHK;
      S_MUL_LAST: state_next = S_OUT;
      S_MUL_ADDDONE: begin
        rf_raddr   = R_T;
        state_next = S_MUL_RDT;
      end
      S_MUL_RDT:     state_next = S_DBLCHK;
      S_MUL_DBLDONE: state_next = S_MUL_STEP;
      S_OUT:         state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT) begin
      res_valid <= 1'b1;
    end else if (res_valid && !out_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Datapath registers, updated per state.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q   <= cmd_t'(cmd);
          scal_q  <= scalar;
          px <= x1; py <= y1; qx <= x2; qy <= y2;
          num <= curve_a;
          red_idx <= '0;
          res_x <= '0; res_y <= '0;
        end
      end
      // Restoring remainder, one bit per cycle, for the five inputs.
      S_RED: begin
        unique case (red_idx)
          3'd0: red_val <= px;
          3'd1: red_val <= py;
          3'd2: red_val <= qx;
          3'd3: red_val <= qy;
          default: red_val <= num;
        endcase
        red_rem <= '0;
        red_cnt <= ExpCntBits'(FeW);
      end
      S_REDW: begin
        if (red_cnt != '0) begin
          red_rem <= (rr_shift >= {1'b0, modulus}) ?
                     FeW'(rr_shift - {1'b0, modulus}) : FeW'(rr_shift);
          red_val <= {red_val[FeW-2:0], 1'b0};
          red_cnt <= red_cnt - ExpCntBits'(1);
        end else begin
          unique case (red_idx)
            3'd0: px <= red_rem;
            3'd1: py <= red_rem;
            3'd2: qx <= red_rem;
            3'd3: qy <= red_rem;
            default: num <= red_rem;
          endcase
          red_idx <= red_idx + 3'd1;
        end
      end
      // Negate the second point for subtract, set up the scalar loop.
      S_SEL: begin
        op_from_mul <= (cmd_q == CMD_MUL);
        bit_cnt     <= '0;
        if (cmd_q == CMD_SUB) begin
          qy <= (qy == '0) ? '0 : modulus - qy;
        end
      end
      // Add: special cases, else chord slope.
      S_ADDCHK: begin
        op_dbl <= 1'b0;
        if (px == '0 && py == '0) begin
          res_x <= qx; res_y <= qy;
        end else if (qx == '0 && qy == '0) begin
          res_x <= px; res_y <= py;
        end else if (px == qx) begin
          if (py != qy) begin
            res_x <= '0; res_y <= '0;
          end
        end else begin
          num <= fsub(qy, py, modulus);
          den <= fsub(qx, px, modulus);
        end
      end
      S_DBLCHK: begin
        op_dbl <= 1'b1;
        if (py == '0) begin
          res_x <= '0; res_y <= '0;
        end
      end
      S_SQXW: begin
        if (mdone) begin
          num <= fadd(fadd(fadd(mprod, mprod, modulus), mprod, modulus),
                      rf_rdata.x, modulus);
          den <= fadd(py, py, modulus);
        end
      end
      // Inverse by den^(m-2), square-and-multiply, LSB first.
      S_INV_INIT: begin
        inv_r   <= FeW'(1);
        inv_b   <= den;
        exp_q   <= modulus - FeW'(2);
        exp_cnt <= ExpCntBits'(FeW);
      end
      S_INV_MULW: if (mdone) inv_r <= mprod;
      S_INV_SQW: begin
        if (mdone) begin
          inv_b   <= mprod;
          exp_q   <= exp_q >> 1;
          exp_cnt <= exp_cnt - ExpCntBits'(1);
        end
      end
      S_SLOPEW: if (mdone) slope <= mprod;
      S_MSQW: begin
        if (mdone) rx <= fsub(fsub(mprod, px, modulus), op_dbl ? px : qx, modulus);
      end
      S_YMULW: begin
        if (mdone) begin
          res_x <= rx;
          res_y <= fsub(mprod, py, modulus);
        end
      end
      // Operands of the scalar loop arrive from the working memory.
      S_MUL_RDA: begin
        px <= rf_rdata.x; py <= rf_rdata.y;
      end
      S_MUL_RDB: begin
        qx <= rf_rdata.x; qy <= rf_rdata.y;
        op_is_add <= 1'b1;
      end
      S_MUL_RDT: begin
        px <= rf_rdata.x; py <= rf_rdata.y;
        op_is_add <= 1'b0;
      end
      S_MUL_LAST: begin
        res_x <= rf_rdata.x; res_y <= rf_rdata.y;
      end
      S_MUL_DBLDONE: begin
        scal_q  <= scal_q >> 1;
        bit_cnt <= bit_cnt + ScCntBits'(1);
      end
      S_OUT: begin
        x_out       <= res_x;
        y_out       <= res_y;
        at_infinity <= (res_x == '0) && (res_y == '0);
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/ecpa_modmul.sv -----
// Sequential modular multiplier: one bit of the multiplier per cycle,
// shift-add with a conditional subtract after the shift and after the add,
// so every step is two adds and compares. Result is a*b mod m for a, b
// already below m. The product is ready while done is high.
module ecpa_modmul (
  input  logic               clk,
  input  logic               rst,
  input  ecpa_pkg::mm_req_t  req,
  input  ecpa_pkg::fe_t      m,
  output logic               done,
  output ecpa_pkg::fe_t      prod
);
  import ecpa_pkg::*;

  localparam int CntBits = $clog2(FieldBits + 1);

  fe_t                a_reg;
  fe_t                b_reg;
  logic [FieldBits:0] acc;
  logic [CntBits-1:0] cnt;
  logic               busy;
  logic [FieldBits+1:0] dbl;
  logic [FieldBits+1:0] dbl_red;
  logic [FieldBits+1:0] sum;
  logic [FieldBits+1:0] sum_red;

  // Horner step: acc = 2*acc (+a) mod m, most significant bit first.
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
    sum     = dbl_red + (b_reg[FieldBits-1] ? {2'b00, a_reg} : '0);
    sum_red = (sum >= {2'b00, m}) ? sum - {2'b00, m} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(FieldBits);
      end else if (busy) begin
        cnt <= cnt - CntBits'(1);
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_reg <= req.b;
      acc   <= '0;
    end else if (busy) begin
      acc   <= sum_red[FieldBits:0];
      b_reg <= {b_reg[FieldBits-2:0], 1'b0};
    end
  end

  assign prod = acc[FieldBits-1:0];

endmodule
